// ----- hw/rtl/gradient_template_score_macros.svh -----
// Assertion macros for the gradient template scorer RTL.
`ifndef GRADIENT_TEMPLATE_SCORE_MACROS_SVH
`define GRADIENT_TEMPLATE_SCORE_MACROS_SVH

// Clocked check, masked while aresetn is low.
`define GTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds through reset.
`define GTS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hw/rtl/gts_pkg.sv -----
// Types and constants for the gradient template scorer.
`default_nettype none

package gts_pkg;

    localparam int MIN_SCORE_W = 15;
    localparam int IMG_DIM_W   = 13;
    localparam int CFG_DATA_W  = 15;
    localparam int CFG_INDEX_W = 2;

    localparam int SUM_W   = 26;
    localparam int COUNT_W = 11;
    localparam int TERM_W  = 19;
    localparam int PROD_W  = 32;
    localparam int BOUND_W = 28;
    localparam int THR_W   = 26;

    localparam logic [MIN_SCORE_W-1:0] MIN_SCORE_RST = 15'd13107;
    localparam logic [IMG_DIM_W-1:0]   IMG_DIM_RST   = 13'd256;

    localparam logic signed [15:0] ONE_Q14    = 16'sd16384;
    localparam logic signed [32:0] ROUND_HALF = 33'sd8192;
    localparam logic signed [26:0] SUM_LIMIT  = 27'sd16777216;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 11'd2047;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIN_SCORE    = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_e;

    // Placement tags that ride along with each edge through the pipe.
    typedef struct packed {
        logic [10:0]        template_index;
        logic [11:0]        anchor_row;
        logic [11:0]        anchor_col;
        logic [COUNT_W-1:0] edge_count;
        logic               last;
    } tag_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gradient_template_score.sv -----
// Gradient template scorer: pipelined dot-product accumulation with early cut.
// Results reach m_valid through the result register behind stage 3. One edge
//   request per cycle unless a last edge waits on a full result register; the
//   accumulator add/saturate/compare at stage 3 closes the only feedback loop.
// Reset (aresetn low, synchronous): pipe and result empty, accumulator cleared,
//   min_score 13107, image 256 x 256.
`default_nettype none
`include "gradient_template_score_macros.svh"

module gradient_template_score #(
    parameter int GROUP_SIZE = 8
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    // Configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [gts_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [gts_pkg::CFG_DATA_W-1:0]   cfg_data,

    // Edge request channel
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [10:0]                      s_template_index,
    input  wire logic [11:0]                      s_anchor_row,
    input  wire logic [11:0]                      s_anchor_col,
    input  wire logic signed [13:0]               s_point_x,
    input  wire logic signed [13:0]               s_point_y,
    input  wire logic signed [15:0]               s_tmpl_gx,
    input  wire logic signed [15:0]               s_tmpl_gy,
    input  wire logic signed [15:0]               s_img_gx,
    input  wire logic signed [15:0]               s_img_gy,
    input  wire logic [10:0]                      s_edge_count,
    input  wire logic                             s_last,

    // Result channel
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [11:0]                           m_out_row,
    output logic [11:0]                           m_out_col,
    output logic [10:0]                           m_out_template,
    output logic signed [25:0]                    m_dot_sum,
    output logic [10:0]                           m_edges_used,
    output logic                                  m_accepted,
    output logic                                  m_cut_short
);

    import gts_pkg::*;

    // Group counter width; a group of one still needs a bit.
    localparam int GW = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
    localparam logic [GW-1:0] GROUP_LAST = GW'(GROUP_SIZE - 1);

    // ------------------------------------------------------------------
    // Configuration registers. The user must write only while idle; the
    // block does not enforce it. No hazard handling against in-flight edges.
    // ------------------------------------------------------------------
    logic [MIN_SCORE_W-1:0] min_score_reg;
    logic [IMG_DIM_W-1:0]   image_width_reg;
    logic [IMG_DIM_W-1:0]   image_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_score_reg    <= MIN_SCORE_RST;
            image_width_reg  <= IMG_DIM_RST;
            image_height_reg <= IMG_DIM_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MIN_SCORE:    min_score_reg    <= cfg_data[MIN_SCORE_W-1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMG_DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IMG_DIM_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipe control. Each stage loads when empty or when the next one
    // moves, so bubbles collapse and input keeps flowing while a result
    // waits. Stage 3 needs the result register only for a last edge.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic en1, en2, en3, s3_take, s3_emit;
    tag_t tag1_reg, tag2_reg, tag3_reg;

    assign s3_take = v3_reg && (!tag3_reg.last || !out_valid_reg || m_ready);
    assign s3_emit = s3_take && tag3_reg.last;
    assign en3     = !v3_reg || s3_take;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    // ------------------------------------------------------------------
    // Stage 1: request register
    // ------------------------------------------------------------------
    logic signed [13:0] px1_reg, py1_reg;
    logic signed [15:0] tgx1_reg, tgy1_reg, igx1_reg, igy1_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            tag1_reg.template_index <= s_template_index;
            tag1_reg.anchor_row     <= s_anchor_row;
            tag1_reg.anchor_col     <= s_anchor_col;
            tag1_reg.edge_count     <= s_edge_count;
            tag1_reg.last           <= s_last;
            px1_reg  <= s_point_x;
            py1_reg  <= s_point_y;
            tgx1_reg <= s_tmpl_gx;
            tgy1_reg <= s_tmpl_gy;
            igx1_reg <= s_img_gx;
            igy1_reg <= s_img_gy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 -> 2: border test, gradient products, threshold products
    // ------------------------------------------------------------------
    logic                      in_image;
    logic signed [15:0]        igx_m, igy_m, min_off;
    logic signed [PROD_W-1:0]  prod_x_next, prod_y_next;
    logic signed [BOUND_W-1:0] bmul_next;
    logic [THR_W-1:0]          thr_next;

    assign in_image = !px1_reg[13] && !py1_reg[13]
                 && ($signed({px1_reg[13], px1_reg}) < $signed({2'b00, image_width_reg}))
                 && ($signed({py1_reg[13], py1_reg}) < $signed({2'b00, image_height_reg}));
    assign igx_m  = in_image ? igx1_reg : 16'sd0;
    assign igy_m  = in_image ? igy1_reg : 16'sd0;

    assign prod_x_next = tgx1_reg * igx_m;
    assign prod_y_next = tgy1_reg * igy_m;

    // edge_count*(min-1.0): base of the early-cut bound
    assign min_off   = $signed({1'b0, min_score_reg}) - ONE_Q14;
    assign bmul_next = $signed({17'b0, tag1_reg.edge_count})
                     * $signed({{12{min_off[15]}}, min_off});
    // edge_count*min: final accept threshold
    assign thr_next  = {15'b0, tag1_reg.edge_count} * {11'b0, min_score_reg};

    logic signed [PROD_W-1:0]  prod_x2_reg, prod_y2_reg;
    logic signed [BOUND_W-1:0] bmul2_reg, bmul3_reg;
    logic [THR_W-1:0]          thr2_reg, thr3_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            tag2_reg    <= tag1_reg;
            prod_x2_reg <= prod_x_next;
            prod_y2_reg <= prod_y_next;
            bmul2_reg   <= bmul_next;
            thr2_reg    <= thr_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 -> 3: Q2.28 sum, round half up to Q.14 (arithmetic shift)
    // ------------------------------------------------------------------
    logic signed [32:0]       dot_q28, dot_rnd;
    logic signed [TERM_W-1:0] term_next, term3_reg;

    assign dot_q28   = {prod_x2_reg[PROD_W-1], prod_x2_reg}
                     + {prod_y2_reg[PROD_W-1], prod_y2_reg};
    assign dot_rnd   = dot_q28 + ROUND_HALF;
    assign term_next = dot_rnd[32:14];

    always_ff @(posedge aclk) begin
        if (en3) begin
            tag3_reg  <= tag2_reg;
            term3_reg <= term_next;
            bmul3_reg <= bmul2_reg;
            thr3_reg  <= thr2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: accumulate, saturate, group check
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]   sum_reg, sum_next, sum_acc;
    logic [COUNT_W-1:0]        seen_reg, seen_next, seen_inc;
    logic [GW-1:0]             grp_reg, grp_next;
    logic                      rejected_reg, rejected_next, rej_acc;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [BOUND_W-1:0] bound;
    logic                      count_ok, group_done, check, cut, accept_now;

    assign sum_wide   = {sum_reg[SUM_W-1], sum_reg}
                      + {{(SUM_W + 1 - TERM_W){term3_reg[TERM_W-1]}}, term3_reg};
    assign count_ok   = seen_reg != COUNT_MAX;
    assign seen_inc   = seen_reg + 1'b1;
    assign group_done = grp_reg == GROUP_LAST;
    // seen is a group multiple here, so seen <= edge_count also means
    // seen <= edge_count rounded down to a group multiple
    assign check      = count_ok && group_done && (seen_inc <= tag3_reg.edge_count);
    assign bound      = bmul3_reg + $signed({3'b000, seen_inc, 14'b0});

    always_comb begin
        sum_acc   = sum_reg;
        seen_next = seen_reg;
        grp_next  = grp_reg;
        cut       = 1'b0;
        if (!rejected_reg) begin
            if (sum_wide > SUM_LIMIT) begin
                sum_acc = SUM_LIMIT[SUM_W-1:0];
            end else if (sum_wide < -SUM_LIMIT) begin
                sum_acc = SUM_W'(-SUM_LIMIT);
            end else begin
                sum_acc = sum_wide[SUM_W-1:0];
            end
            if (count_ok) begin
                seen_next = seen_inc;
                grp_next  = group_done ? '0 : grp_reg + 1'b1;
            end
            cut = check && ($signed({{2{sum_acc[SUM_W-1]}}, sum_acc}) < bound);
        end
        rej_acc    = rejected_reg || cut;
        accept_now = !rej_acc
                  && ($signed({sum_acc[SUM_W-1], sum_acc}) >= $signed({1'b0, thr3_reg}));

        sum_next      = sum_acc;
        rejected_next = rej_acc;
        if (tag3_reg.last) begin
            // placement done: clear for the next one
            sum_next      = '0;
            seen_next     = '0;
            grp_next      = '0;
            rejected_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Control state and result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            seen_reg      <= '0;
            grp_reg       <= '0;
            rejected_reg  <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            out_valid_reg <= (out_valid_reg && !m_ready) || s3_emit;
            if (s3_take) begin
                sum_reg      <= sum_next;
                seen_reg     <= seen_next;
                grp_reg      <= grp_next;
                rejected_reg <= rejected_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_emit) begin
            m_out_row      <= tag3_reg.anchor_row;
            m_out_col      <= tag3_reg.anchor_col;
            m_out_template <= tag3_reg.template_index;
            m_dot_sum      <= sum_acc;
            m_edges_used   <= tag3_reg.edge_count;
            m_accepted     <= accept_now;
            m_cut_short    <= rej_acc;
        end
    end

    assign m_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `GTS_ASSERT(a_sum_in_range,
        ($signed({sum_reg[SUM_W-1], sum_reg}) <= SUM_LIMIT)
        && ($signed({sum_reg[SUM_W-1], sum_reg}) >= -SUM_LIMIT),
        "running sum outside saturation range")
    `GTS_ASSERT(a_cut_not_accepted, m_valid |-> !(m_accepted && m_cut_short),
        "cut placement reported as accepted")
    `GTS_ASSERT(a_reject_sticky, (rejected_reg && !s3_emit) |=> rejected_reg,
        "reject flag dropped inside a placement")
    `GTS_ASSERT(a_clear_after_last, s3_emit |=> (sum_reg == '0 && seen_reg == '0
        && !rejected_reg && grp_reg == '0), "state not cleared after last edge")
    `GTS_ASSERT(a_group_in_range, grp_reg <= GROUP_LAST,
        "group counter past group size")
    `GTS_ASSERT_ALWAYS(a_reset_clears_output, !aresetn |=> !m_valid,
        "result valid right after reset")

endmodule

`default_nettype wire

// ----- bench/gradient_template_score_tb.sv -----
// Self-checking testbench for the gradient template scorer: directed and random edge streams.

module gradient_template_score_tb;
    import gts_pkg::*;

    // Scorer behavior constants (kept local to the predictor).
    localparam int     GROUP       = 8;          // edges between early-cut checks
    localparam int     UNIT        = 16384;      // 1.0 in Q.14
    localparam longint SAT         = 64'sd16777216;
    localparam int     SEEN_LIMIT  = 2047;       // edge counter sticks here
    localparam int     HOLD_CYCLES = 80;         // long result backpressure
    localparam int     PHASE_ITEMS = 60;         // random requests per config phase
    localparam int     SAT_EDGES   = 136;        // full-scale edges per saturating placement

    // One edge request as driven on the s_ channel.
    typedef struct {
        bit [10:0]        template_index;
        bit [11:0]        anchor_row;
        bit [11:0]        anchor_col;
        bit signed [13:0] point_x;
        bit signed [13:0] point_y;
        bit signed [15:0] tmpl_gx;
        bit signed [15:0] tmpl_gy;
        bit signed [15:0] img_gx;
        bit signed [15:0] img_gy;
        bit [10:0]        edge_count;
        bit               last;
    } edge_t;

    // One placement score as seen on the m_ channel.
    typedef struct {
        bit [11:0]        row;
        bit [11:0]        col;
        bit [10:0]        tmpl;
        bit signed [25:0] dot_sum;
        bit [10:0]        edges;
        bit               accepted;
        bit               cut_short;
    } score_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [CFG_INDEX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]          cfg_data;
    logic                           s_valid;
    logic                           s_ready;
    logic [10:0]                    s_template_index;
    logic [11:0]                    s_anchor_row;
    logic [11:0]                    s_anchor_col;
    logic signed [13:0]             s_point_x;
    logic signed [13:0]             s_point_y;
    logic signed [15:0]             s_tmpl_gx;
    logic signed [15:0]             s_tmpl_gy;
    logic signed [15:0]             s_img_gx;
    logic signed [15:0]             s_img_gy;
    logic [10:0]                    s_edge_count;
    logic                           s_last;
    logic                           m_valid;
    logic                           m_ready;
    logic [11:0]                    m_out_row;
    logic [11:0]                    m_out_col;
    logic [10:0]                    m_out_template;
    logic signed [25:0]             m_dot_sum;
    logic [10:0]                    m_edges_used;
    logic                           m_accepted;
    logic                           m_cut_short;

    // Predictor copy of the block's registers and accumulator state.
    int     cfg_min    = 13107;
    int     cfg_width  = 256;
    int     cfg_height = 256;
    longint acc_sum    = 0;
    int     seen_count = 0;
    bit     cut_flag   = 1'b0;

    // Scores still owed by the block, oldest first.
    score_t pending_scores[$];

    // Directed stimulus table; known rows carry a hand-written score.
    edge_t  plan_edges[$];
    bit     plan_known[$];
    score_t plan_want[$];

    int errors         = 0;
    int sent_count     = 0;
    int scores_checked = 0;
    int accepted_seen  = 0;
    int cut_seen       = 0;

    // Receiver shaping: calm turns off random stalls; each bump of hold_asks
    // asks for one long stall that the receiver counts out on its own.
    bit calm         = 1'b0;
    int hold_asks    = 0;
    int hold_served  = 0;
    int hold_left    = 0;

    gradient_template_score dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_template_index (s_template_index),
        .s_anchor_row     (s_anchor_row),
        .s_anchor_col     (s_anchor_col),
        .s_point_x        (s_point_x),
        .s_point_y        (s_point_y),
        .s_tmpl_gx        (s_tmpl_gx),
        .s_tmpl_gy        (s_tmpl_gy),
        .s_img_gx         (s_img_gx),
        .s_img_gy         (s_img_gy),
        .s_edge_count     (s_edge_count),
        .s_last           (s_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_row        (m_out_row),
        .m_out_col        (m_out_col),
        .m_out_template   (m_out_template),
        .m_dot_sum        (m_dot_sum),
        .m_edges_used     (m_edges_used),
        .m_accepted       (m_accepted),
        .m_cut_short      (m_cut_short)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Hard stop: several times the slowest legal run.
    initial begin
        #10_000_000;
        $display("timeout: %0d scores still outstanding", pending_scores.size());
        $display("gradient_template_score_tb: done, errors");
        $finish;
    end

    // Result side ready: random stalls, a calm stretch, and one long hold.
    always @(posedge aclk) begin
        if (hold_served != hold_asks) begin
            hold_served = hold_asks;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 24);
        end
    end

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Every accepted score is matched against the oldest one owed.
    always @(posedge aclk) begin : score_monitor
        score_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_scores.size() == 0) begin
                errors++;
                $display("%0t: unexpected score, row %0d col %0d sum %0d", $time,
                         m_out_row, m_out_col, m_dot_sum);
            end else begin
                want = pending_scores.pop_front();
                check_field("out_row",      want.row,       m_out_row);
                check_field("out_col",      want.col,       m_out_col);
                check_field("out_template", want.tmpl,      m_out_template);
                check_field("dot_sum",      want.dot_sum,   m_dot_sum);
                check_field("edges_used",   want.edges,     m_edges_used);
                check_field("accepted",     want.accepted,  m_accepted);
                check_field("cut_short",    want.cut_short, m_cut_short);
            end
            scores_checked++;
            if (m_accepted === 1'b1) accepted_seen++;
            if (m_cut_short === 1'b1) cut_seen++;
        end
    end

    // Predictor: folds one edge into the running placement score. Returns 1
    // when the edge closes the placement, with the score in r.
    function automatic bit score_edge(input edge_t e, output score_t r);
        longint gx, gy, prod, ecnt, bound;
        bit     in_image;
        ecnt = longint'(e.edge_count);
        r    = '{default: 0};
        if (!cut_flag) begin
            in_image = e.point_x >= 0 && e.point_y >= 0 &&
                       e.point_x < cfg_width && e.point_y < cfg_height;
            gx   = in_image ? longint'(e.img_gx) : 0;
            gy   = in_image ? longint'(e.img_gy) : 0;
            prod = longint'(e.tmpl_gx) * gx + longint'(e.tmpl_gy) * gy;
            // Q2.28 -> Q.14, nearest with ties upward, i.e. floor(p + half)
            acc_sum += (prod + 8192) >>> 14;
            if (acc_sum > SAT) acc_sum = SAT;
            if (acc_sum < -SAT) acc_sum = -SAT;
            if (seen_count < SEEN_LIMIT) begin
                seen_count++;
                if (seen_count % GROUP == 0 && seen_count <= ecnt - ecnt % GROUP) begin
                    bound = ecnt * (cfg_min - UNIT) + longint'(seen_count) * UNIT;
                    if (acc_sum < bound) cut_flag = 1'b1;
                end
            end
        end
        if (!e.last) return 1'b0;
        r.row       = e.anchor_row;
        r.col       = e.anchor_col;
        r.tmpl      = e.template_index;
        r.dot_sum   = acc_sum[25:0];
        r.edges     = e.edge_count;
        r.accepted  = !cut_flag && acc_sum >= ecnt * cfg_min;
        r.cut_short = cut_flag;
        acc_sum    = 0;
        seen_count = 0;
        cut_flag   = 1'b0;
        return 1'b1;
    endfunction

    function automatic edge_t mk_edge(input int tmpl, input int arow, input int acol,
                                      input int px, input int py, input int tgx,
                                      input int tgy, input int igx, input int igy,
                                      input int ec, input bit fin);
        edge_t e;
        e.template_index = 11'(tmpl);
        e.anchor_row     = 12'(arow);
        e.anchor_col     = 12'(acol);
        e.point_x        = 14'(px);
        e.point_y        = 14'(py);
        e.tmpl_gx        = 16'(tgx);
        e.tmpl_gy        = 16'(tgy);
        e.img_gx         = 16'(igx);
        e.img_gy         = 16'(igy);
        e.edge_count     = 11'(ec);
        e.last           = fin;
        return e;
    endfunction

    task automatic add_row(input edge_t e, input bit known, input int sum,
                           input bit acc, input bit cut);
        score_t s;
        s.row       = e.anchor_row;
        s.col       = e.anchor_col;
        s.tmpl      = e.template_index;
        s.dot_sum   = 26'(sum);
        s.edges     = e.edge_count;
        s.accepted  = acc;
        s.cut_short = cut;
        plan_edges.insert(plan_edges.size(), e);
        plan_known.insert(plan_known.size(), known);
        plan_want.insert(plan_want.size(), s);
    endtask

    // Offer one edge request, with random idle cycles ahead of it, and hold
    // it until taken. Valid stays high on return so back-to-back requests
    // never toggle it within a step.
    task automatic send_edge(input edge_t e, input bit known, input score_t want);
        score_t got;
        bit     closes;
        while (!calm && $urandom_range(0, 99) < 24) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_template_index <= e.template_index;
        s_anchor_row     <= e.anchor_row;
        s_anchor_col     <= e.anchor_col;
        s_point_x        <= e.point_x;
        s_point_y        <= e.point_y;
        s_tmpl_gx        <= e.tmpl_gx;
        s_tmpl_gy        <= e.tmpl_gy;
        s_img_gx         <= e.img_gx;
        s_img_gy         <= e.img_gy;
        s_edge_count     <= e.edge_count;
        s_last           <= e.last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
        closes = score_edge(e, got);
        if (closes) pending_scores.insert(pending_scores.size(), known ? want : got);
    endtask

    // Stop offering, wait for every owed score, then let the pipe empty of
    // edges that close no placement.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_config(input int min_q14, input int width, input int height);
        cfg_valid <= 1'b1;
        cfg_index <= REG_MIN_SCORE;
        cfg_data  <= 15'(min_q14);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_min   = min_q14 & 16'h7FFF;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= 15'(width);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_width = width & 16'h1FFF;
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= 15'(height);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_height = height & 16'h1FFF;
        cfg_valid <= 1'b0;
    endtask

    // One placement: unit-length template gradients, image gradients that
    // match with probability quality%, points scattered around the anchor.
    // Some placements end early or late, and some requests carry noise.
    task automatic random_placement(input int ec, input int quality);
        edge_t  e;
        score_t unused;
        int     n, k, tgx, tgy, tmpl, arow, acol;
        unused = '{default: 0};
        tmpl   = $urandom_range(0, 2047);
        if (cfg_width == 0 || cfg_height == 0 || $urandom_range(0, 4) == 0) begin
            arow = $urandom_range(0, 4095);
            acol = $urandom_range(0, 4095);
        end else begin
            arow = $urandom_range(0, (cfg_height > 4096 ? 4096 : cfg_height) - 1);
            acol = $urandom_range(0, (cfg_width > 4096 ? 4096 : cfg_width) - 1);
        end
        n = ec;
        if ($urandom_range(0, 5) == 0) n = ec + int'($urandom_range(0, 8)) - 4;
        if (n < 1) n = 1;
        for (k = 0; k < n; k++) begin
            tgx = int'($urandom_range(0, 2 * UNIT)) - UNIT;
            tgy = $rtoi($sqrt(268435456.0 - real'(tgx * tgx)));
            if ($urandom_range(0, 1)) tgy = -tgy;
            e = mk_edge(tmpl, arow, acol,
                        acol + int'($urandom_range(0, 40)) - 20,
                        arow + int'($urandom_range(0, 40)) - 20,
                        tgx, tgy, tgx, tgy, ec, k == n - 1);
            if ($urandom_range(0, 99) >= quality) begin
                e.img_gx = 16'(int'($urandom_range(0, 2 * UNIT)) - UNIT);
                e.img_gy = 16'(int'($urandom_range(0, 2 * UNIT)) - UNIT);
            end
            // noise: full-width values, including those outside the nominal ranges
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0: begin
                        e.point_x = 14'($urandom);
                        e.point_y = 14'($urandom);
                    end
                    1: begin
                        e.tmpl_gx = 16'($urandom);
                        e.tmpl_gy = 16'($urandom);
                        e.img_gx  = 16'($urandom);
                        e.img_gy  = 16'($urandom);
                    end
                    2: e.edge_count = 11'($urandom);
                    default: begin
                        e.template_index = 11'($urandom);
                        e.anchor_row     = 12'($urandom);
                        e.anchor_col     = 12'($urandom);
                    end
                endcase
            end
            send_edge(e, 1'b0, unused);
        end
    endtask

    task automatic random_run(input int budget);
        int stop_at, ec, quality;
        stop_at = sent_count + budget;
        while (sent_count < stop_at) begin
            ec      = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8)
                                                  : $urandom_range(9, 32);
            quality = $urandom_range(0, 1) ? $urandom_range(85, 100)
                                           : $urandom_range(0, 100);
            random_placement(ec, quality);
        end
    endtask

    // Single-edge placements while the receiver holds off: scores pile up
    // and the block must stall its request side.
    task automatic stall_burst();
        edge_t  e;
        score_t unused;
        int     k;
        unused = '{default: 0};
        hold_asks++;
        for (k = 0; k < 30; k++) begin
            e = mk_edge($urandom_range(0, 2047), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 300),
                        $urandom_range(0, 300), $urandom, $urandom, $urandom, $urandom,
                        9, 1'b1);
            send_edge(e, 1'b0, unused);
        end
    endtask

    // Two long placements with full-scale gradients: the first climbs into
    // the upper saturation limit, the second into the lower one. Counts
    // below a group keep the early-cut checks off.
    task automatic saturating_run();
        edge_t  e;
        score_t unused;
        int     k, ig;
        unused = '{default: 0};
        for (k = 0; k < 2 * SAT_EDGES; k++) begin
            ig = (k < SAT_EDGES) ? -32768 : 32767;
            e  = mk_edge(77, 5, 6, 0, 0, -32768, -32768, ig, ig,
                         $urandom_range(0, GROUP - 1),
                         k == SAT_EDGES - 1 || k == 2 * SAT_EDGES - 1);
            send_edge(e, 1'b0, unused);
        end
    endtask

    initial begin : stimulus
        int     i, k;
        score_t unused;
        unused           = '{default: 0};
        aresetn          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = REG_MIN_SCORE;
        cfg_data         = '0;
        s_valid          = 1'b0;
        s_template_index = '0;
        s_anchor_row     = '0;
        s_anchor_col     = '0;
        s_point_x        = '0;
        s_point_y        = '0;
        s_tmpl_gx        = '0;
        s_tmpl_gy        = '0;
        s_img_gx         = '0;
        s_img_gy         = '0;
        s_edge_count     = '0;
        s_last           = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table, reset configuration (min 0.8, 256 x 256).
        // Single-edge placements: one unit product, outside on each border.
        add_row(mk_edge(0, 0, 0, 10, 10, UNIT, 0, UNIT, 0, 9, 1), 1, UNIT, 0, 0);
        add_row(mk_edge(2047, 4095, 4095, -1, 10, UNIT, UNIT, UNIT, UNIT, 1024, 1),
                1, 0, 0, 0);
        add_row(mk_edge(1, 7, 9, 256, 0, UNIT, UNIT, UNIT, UNIT, 9, 1), 1, 0, 0, 0);
        add_row(mk_edge(2, 7, 9, -8192, 8191, UNIT, UNIT, UNIT, UNIT, 9, 1),
                1, 0, 0, 0);
        add_row(mk_edge(3, 7, 9, 0, 256, UNIT, UNIT, UNIT, UNIT, 9, 1), 1, 0, 0, 0);
        // far corner, both components negative: two units
        add_row(mk_edge(4, 255, 255, 255, 255, -UNIT, -UNIT, -UNIT, -UNIT, 9, 1),
                1, 2 * UNIT, 0, 0);
        // rounding: half rounds up, minus half rounds to zero, just below goes down
        add_row(mk_edge(5, 1, 1, 0, 0, 1, 0, 8192, 0, 9, 1), 1, 1, 0, 0);
        add_row(mk_edge(6, 1, 1, 0, 0, -1, 0, 8192, 0, 9, 1), 1, 0, 0, 0);
        add_row(mk_edge(7, 1, 1, 0, 0, -1, 0, 8193, 0, 9, 1), 1, -1, 0, 0);
        // most negative gradients everywhere: 8 units, enough to pass 9 x 0.8
        add_row(mk_edge(8, 100, 100, 100, 100, -32768, -32768, -32768, -32768, 9, 1),
                1, 8 * UNIT, 1, 0);
        // zero edge count: threshold is zero
        add_row(mk_edge(9, 3, 3, 3, 3, UNIT, UNIT, UNIT, UNIT, 0, 1), 1, 2 * UNIT, 1, 0);
        // eight dead edges with a count of 8: the cut lands on the last edge
        for (k = 0; k < 8; k++)
            add_row(mk_edge(10, 20, 30, 20 + k, 30, 0, 0, 0, 0, 8, k == 7),
                    k == 7, 0, 0, 1);
        for (i = 0; i < plan_edges.size(); i++)
            send_edge(plan_edges[i], plan_known[i], plan_want[i]);

        // Random phases, one configuration each.
        random_run(PHASE_ITEMS);

        drain();
        set_config(0, 4096, 4096);
        calm = 1'b1;                        // no stalls on either side here
        random_run(PHASE_ITEMS);
        calm = 1'b0;

        drain();
        set_config(UNIT, 15'h7FFF, 1);      // upper bits of width are dropped
        random_run(PHASE_ITEMS);

        drain();
        set_config(15'h7FFF, 0, 0);         // empty image, unreachable minimum
        random_run(PHASE_ITEMS);

        drain();
        set_config($urandom_range(8000, 16000), $urandom_range(1, 4096),
                   $urandom_range(1, 4096));
        random_run(PHASE_ITEMS / 2);
        stall_burst();
        random_run(PHASE_ITEMS / 2);

        drain();
        set_config(13107, 640, 480);
        random_run(PHASE_ITEMS / 2);
        drain();                            // sender waits out every score
        saturating_run();
        random_run(PHASE_ITEMS / 2);

        drain();
        $display("%0d edge requests over six register settings, %0d scores checked",
                 sent_count, scores_checked);
        $display("%0d placements accepted, %0d cut short", accepted_seen, cut_seen);
        if (errors == 0)
            $display("gradient_template_score_tb: done, clean");
        else
            $display("gradient_template_score_tb: done, errors");
        $finish;
    end

endmodule
